@@ hw/rtl/ssr_pkg.sv @@
// Shared types, constants and helpers for the six-axis servo ramp generator.
package ssr_pkg;

    localparam int NUM_AXES            = 6;
    localparam int ANGLE_BITS_DEF      = 8;
    localparam int REPORT_INTERVAL_DEF = 10;

    localparam int IN_ANGLE_W  = 8;
    localparam int OUT_ANGLE_W = 8;
    localparam int STEP_W      = 4;
    localparam int PERIOD_W    = 5;
    localparam int CFG_ADDR_W  = 1;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    localparam int M_PERIOD_LSB = NUM_AXES * OUT_ANGLE_W;

    localparam logic [IN_ANGLE_W-1:0] PERIOD_MIN = 8'd10;
    localparam logic [IN_ANGLE_W-1:0] PERIOD_MAX = 8'd30;

    localparam logic [IN_ANGLE_W-1:0] AXIS_LO [NUM_AXES] =
        '{8'd0, 8'd15, 8'd0, 8'd0, 8'd0, 8'd10};
    localparam logic [IN_ANGLE_W-1:0] AXIS_HI [NUM_AXES] =
        '{8'd180, 8'd165, 8'd180, 8'd180, 8'd180, 8'd73};
    localparam logic [IN_ANGLE_W-1:0] AXIS_RESET [NUM_AXES] =
        '{8'd0, 8'd140, 8'd0, 8'd10, 8'd0, 8'd10};

    localparam logic [STEP_W-1:0] STEP_RESET = 4'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BASE_STEP  = 1'b0,
        CFG_JOINT_STEP = 1'b1
    } cfg_addr_t;

    typedef enum logic {
        OP_MOVE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // per-axis status from the ramp unit
    typedef struct packed {
        logic first_arrival;
        logic at_target;
    } axis_stat_t;

    typedef struct packed {
        logic [M_TDATA_W-1:0] tdata;
        logic [M_TUSER_W-1:0] tuser;
        logic                 last;
    } result_t;

    function automatic logic [IN_ANGLE_W-1:0] clamp8(
        input logic [IN_ANGLE_W-1:0] v,
        input logic [IN_ANGLE_W-1:0] lo,
        input logic [IN_ANGLE_W-1:0] hi
    );
        logic [IN_ANGLE_W-1:0] r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/ssr_axis.sv @@
// One-axis ramp step: snap when close, otherwise one step toward the target.
module ssr_axis #(
    parameter int ANGLE_BITS = ssr_pkg::ANGLE_BITS_DEF
) (
    input  logic [ANGLE_BITS-1:0]      pos,
    input  logic [ANGLE_BITS-1:0]      tgt,
    input  logic [ssr_pkg::STEP_W-1:0] step,
    input  logic                       arrived_flag,
    output logic [ANGLE_BITS-1:0]      pos_next,
    output ssr_pkg::axis_stat_t        stat
);
    import ssr_pkg::*;

    logic                  at_tgt;
    logic                  up;
    logic [ANGLE_BITS-1:0] gap;
    logic [STEP_W:0]       step2;
    logic                  near;
    logic [ANGLE_BITS-1:0] stepped;

    assign at_tgt  = (pos == tgt);
    assign up      = (tgt > pos);
    assign gap     = up ? (tgt - pos) : (pos - tgt);
    assign step2   = {step, 1'b0};
    assign near    = (gap < ANGLE_BITS'(step2));
    assign stepped = up ? (pos + ANGLE_BITS'(step)) : (pos - ANGLE_BITS'(step));

    assign pos_next = at_tgt ? pos : (near ? tgt : stepped);

    assign stat.first_arrival = at_tgt && !arrived_flag;
    assign stat.at_target     = (pos_next == tgt);

endmodule

@@ hw/rtl/six_axis_servo_ramp.sv @@
// Top level of the six-axis servo ramp generator.
// Output: each accepted result goes to the output register, or to the skid register
// while m_axis stalls. Throughput: one transaction per cycle while the skid is empty;
// a result register plus a skid register let s_axis accept one more while m_axis stalls.
// Reset: positions and targets go to 0,140,0,10,0,10, step sizes to 2,
// tick period to 10 ms, no move active and the output side empty.
module six_axis_servo_ramp #(
    parameter int REPORT_INTERVAL = ssr_pkg::REPORT_INTERVAL_DEF,
    parameter int ANGLE_BITS      = ssr_pkg::ANGLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [ssr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ssr_pkg::STEP_W-1:0]     cfg_wdata,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // step_delay, target_base, target_shoulder, target_elbow,
    // target_wrist_tilt, target_wrist_turn, target_grip (8 bits each)
    input  logic [ssr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [ssr_pkg::S_TUSER_W-1:0]  s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pos_base, pos_shoulder, pos_elbow, pos_wrist_tilt, pos_wrist_turn,
    // pos_grip (8 bits each), tick_period_ms (5 bits), 3 zero bits
    output logic [ssr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // report, moving
    output logic [ssr_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    // arrived
    output logic                           m_axis_tlast
);
    import ssr_pkg::*;

    localparam int TICK_W = $clog2(REPORT_INTERVAL + 1);

    logic [STEP_W-1:0] base_step_reg;
    logic [STEP_W-1:0] joint_step_reg;

    logic [NUM_AXES-1:0][ANGLE_BITS-1:0] pos_reg;
    logic [NUM_AXES-1:0][ANGLE_BITS-1:0] pos_next;
    logic [NUM_AXES-1:0][ANGLE_BITS-1:0] tgt_reg;
    logic [NUM_AXES-1:0][ANGLE_BITS-1:0] tgt_next;
    logic [NUM_AXES-1:0]                 flag_reg;
    logic [NUM_AXES-1:0]                 flag_next;
    logic [TICK_W-1:0]                   tick_reg;
    logic [TICK_W-1:0]                   tick_next;
    logic                                active_reg;
    logic                                active_next;
    logic [PERIOD_W-1:0]                 period_reg;
    logic [PERIOD_W-1:0]                 period_next;

    logic [NUM_AXES-1:0][ANGLE_BITS-1:0] ramp_pos;
    axis_stat_t [NUM_AXES-1:0]           ramp_stat;
    logic [NUM_AXES-1:0][ANGLE_BITS-1:0] tgt_in;
    logic [NUM_AXES-1:0]                 first_arr;
    logic [NUM_AXES-1:0]                 at_after;

    logic          accept;
    logic          pop;
    logic          is_move;
    logic          do_tick;
    logic [TICK_W-1:0] tick_inc;
    logic          tick_wrap;
    logic          report;
    logic          arrived;
    result_t       res;

    logic          out_valid_reg;
    result_t       out_reg;
    logic          skid_valid_reg;
    result_t       skid_reg;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = out_valid_reg && m_axis_tready;
    assign is_move       = (op_t'(s_axis_tuser[0]) == OP_MOVE);
    assign do_tick       = !is_move && active_reg;

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_axis
        assign tgt_in[g] = ANGLE_BITS'(clamp8(
            s_axis_tdata[IN_ANGLE_W*(g+1) +: IN_ANGLE_W], AXIS_LO[g], AXIS_HI[g]));

        ssr_axis #(
            .ANGLE_BITS(ANGLE_BITS)
        ) u_axis (
            .pos          (pos_reg[g]),
            .tgt          (tgt_reg[g]),
            .step         ((g == 0) ? base_step_reg : joint_step_reg),
            .arrived_flag (flag_reg[g]),
            .pos_next     (ramp_pos[g]),
            .stat         (ramp_stat[g])
        );

        assign first_arr[g] = ramp_stat[g].first_arrival;
        assign at_after[g]  = ramp_stat[g].at_target;
    end

    assign tick_inc  = tick_reg + TICK_W'(1);
    assign tick_wrap = (tick_inc >= TICK_W'(REPORT_INTERVAL));

    always_comb
    begin
        pos_next    = pos_reg;
        tgt_next    = tgt_reg;
        flag_next   = flag_reg;
        tick_next   = tick_reg;
        active_next = active_reg;
        period_next = period_reg;
        report      = 1'b0;
        arrived     = 1'b0;
        if (is_move)
        begin
            period_next = PERIOD_W'(clamp8(s_axis_tdata[IN_ANGLE_W-1:0],
                                           PERIOD_MIN, PERIOD_MAX));
            tgt_next    = tgt_in;
            flag_next   = '0;
            tick_next   = '0;
            active_next = 1'b1;
        end
        else if (do_tick)
        begin
            tick_next   = tick_wrap ? '0 : tick_inc;
            pos_next    = ramp_pos;
            flag_next   = flag_reg | first_arr;
            report      = tick_wrap || (|first_arr);
            arrived     = &at_after;
            active_next = !(&at_after);
        end

        res = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            res.tdata[OUT_ANGLE_W*i +: OUT_ANGLE_W] = pos_next[i][OUT_ANGLE_W-1:0];
        end
        res.tdata[M_PERIOD_LSB +: PERIOD_W] = period_next;
        res.tuser = {active_next, report};
        res.last  = arrived;
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_step_reg  <= STEP_RESET;
            joint_step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_BASE_STEP:  base_step_reg  <= cfg_wdata;
                CFG_JOINT_STEP: joint_step_reg <= cfg_wdata;
                default:        base_step_reg  <= base_step_reg;
            endcase
        end
    end

    // move state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pos_reg[i] <= ANGLE_BITS'(AXIS_RESET[i]);
                tgt_reg[i] <= ANGLE_BITS'(AXIS_RESET[i]);
            end
            flag_reg   <= '0;
            tick_reg   <= '0;
            active_reg <= 1'b0;
            period_reg <= PERIOD_W'(PERIOD_MIN);
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            tgt_reg    <= tgt_next;
            flag_reg   <= flag_next;
            tick_reg   <= tick_next;
            active_reg <= active_next;
            period_reg <= period_next;
        end
    end

    // output register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !m_axis_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !m_axis_tready)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.tdata;
    assign m_axis_tuser  = out_reg.tuser;
    assign m_axis_tlast  = out_reg.last;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_arrived_not_moving: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser[1])
        else $error("arrival reported while move still active");

    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg < TICK_W'(REPORT_INTERVAL))
        else $error("tick counter out of range");

    a_move_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_move) |=> (active_reg && flag_reg == '0))
        else $error("move command did not start a move");

    a_idle_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_move && !active_reg) |=> $stable(pos_reg))
        else $error("positions changed on idle tick");
`endif

endmodule
